/* sv/voxel_confusion_counter_macros.svh */
// assertion macros shared by the voxel confusion counter checks
`ifndef VOXEL_CONFUSION_COUNTER_MACROS_SVH
`define VOXEL_CONFUSION_COUNTER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define VCC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voxel_confusion_counter check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define VCC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voxel_confusion_counter check failed");

`endif

/* sv/vcc_pkg.sv */
// shared types, constants and helpers for the voxel confusion counter
`timescale 1ns / 1ps

package vcc_pkg;

  localparam int MAX_DIM     = 1024;
  localparam int DIM_W       = 11;
  localparam int POS_W       = $clog2(MAX_DIM);
  localparam int EXT_W       = (($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W) + 1;
  localparam int MARGIN_W    = 4;
  localparam int SCORE_W     = 16;
  localparam int LABEL_W     = 8;
  localparam int CNT_W       = 31;
  localparam int DEN_W       = CNT_W + 1;
  localparam int FRAC_W      = 16;
  localparam int RATE_W      = FRAC_W + 1;
  localparam int DIVD_W      = CNT_W + FRAC_W + 1;
  localparam int STEP_W      = $clog2(RATE_W);
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int RST_DIM    = 1024;
  localparam int RST_MARGIN = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd4;

  typedef struct packed {
    logic signed [SCORE_W-1:0] threshold;
    logic [DIM_W-1:0]          width;
    logic [DIM_W-1:0]          height;
    logic [DIM_W-1:0]          depth;
    logic [MARGIN_W-1:0]       margin;
  } cfg_t;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_TP,
    CLS_FP,
    CLS_TN,
    CLS_FN
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic last;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_COUNT,
    BK_LOAD,
    BK_PREP,
    BK_STEP
  } bk_state_t;

  // zero acts as one, anything above the maximum is clamped
  function automatic logic [EXT_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [EXT_W-1:0] de;
    de = EXT_W'(d);
    if (d == '0) return EXT_W'(1);
    if (de > EXT_W'(MAX_DIM)) return EXT_W'(MAX_DIM);
    return de;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + CNT_W'(1);
  endfunction

endpackage

/* sv/vcc_front.sv */
// front end: voxel intake, coordinate tracking and classification
`timescale 1ns / 1ps

module vcc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vcc_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [vcc_pkg::SCORE_W-1:0] in_score,
  input  logic [vcc_pkg::LABEL_W-1:0]      in_truth_label,
  input  logic                             q_full,
  output logic                             push,
  output vcc_pkg::q_entry_t                push_entry
);
  import vcc_pkg::*;

  logic [POS_W-1:0] x_r, y_r, z_r;
  logic [POS_W-1:0] x_nxt, y_nxt, z_nxt;
  logic [EXT_W-1:0] w, h, d, m, xe, ye, ze;
  logic             x_end, y_end, z_end, inner, detected, positive, accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    w  = eff_dim(cfg.width);
    h  = eff_dim(cfg.height);
    d  = eff_dim(cfg.depth);
    m  = EXT_W'(cfg.margin);
    xe = EXT_W'(x_r);
    ye = EXT_W'(y_r);
    ze = EXT_W'(z_r);

    x_end = (xe + EXT_W'(1)) >= w;
    y_end = (ye + EXT_W'(1)) >= h;
    z_end = (ze + EXT_W'(1)) >= d;

    inner = (xe >= m) && (xe + m < w) &&
            (ye >= m) && (ye + m < h) &&
            (ze >= m) && (ze + m < d);

    detected = in_score >= cfg.threshold;
    positive = (in_truth_label == '0);

    push_entry.last = x_end && y_end && z_end;
    if (!inner) begin
      push_entry.cls = CLS_NONE;
    end else if (detected) begin
      push_entry.cls = positive ? CLS_TP : CLS_FP;
    end else begin
      push_entry.cls = positive ? CLS_FN : CLS_TN;
    end
    push = accept;

    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (accept) begin
      if (push_entry.last) begin
        x_nxt = '0;
        y_nxt = '0;
        z_nxt = '0;
      end else if (!x_end) begin
        x_nxt = x_r + POS_W'(1);
      end else begin
        x_nxt = '0;
        if (!y_end) begin
          y_nxt = y_r + POS_W'(1);
        end else begin
          y_nxt = '0;
          z_nxt = z_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

/* sv/vcc_queue.sv */
// short fifo of classified voxels between front and back
`timescale 1ns / 1ps

module vcc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vcc_pkg::q_entry_t push_entry,
  input  logic              pop,
  output vcc_pkg::q_entry_t head,
  output logic              head_valid,
  output logic              full
);
  import vcc_pkg::*;

  q_entry_t             mem_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == Q_CNT_W'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* sv/vcc_back.sv */
// back end: confusion counters and the shared serial rate divider
`timescale 1ns / 1ps

module vcc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vcc_pkg::q_entry_t             head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vcc_pkg::RATE_W-1:0]    out_true_positive_rate,
  output logic [vcc_pkg::RATE_W-1:0]    out_false_positive_rate,
  output logic [vcc_pkg::CNT_W-1:0]     out_tp_count,
  output logic [vcc_pkg::CNT_W-1:0]     out_fp_count,
  output logic [vcc_pkg::CNT_W-1:0]     out_tn_count,
  output logic [vcc_pkg::CNT_W-1:0]     out_fn_count,
  output logic                          out_tpr_undefined,
  output logic                          out_fpr_undefined
);
  import vcc_pkg::*;

  bk_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]    tp_r, fp_r, tn_r, fn_r;
  logic [CNT_W-1:0]    tp_nxt, fp_nxt, tn_nxt, fn_nxt;
  logic [CNT_W-1:0]    tp_inc, fp_inc, tn_inc, fn_inc;
  logic [CNT_W-1:0]    otp_r, ofp_r, otn_r, ofn_r;
  logic [CNT_W-1:0]    otp_nxt, ofp_nxt, otn_nxt, ofn_nxt;
  logic [RATE_W-1:0]   tpr_r, fpr_r, tpr_nxt, fpr_nxt;
  logic                tpu_r, fpu_r, tpu_nxt, fpu_nxt;
  logic                valid_r, valid_nxt;
  logic                sel_r, sel_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt, den_sum;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [RATE_W-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    num, oth;
  logic [DIVD_W-1:0]   dividend;
  logic [DEN_W:0]      trial;
  logic                ge;

  assign out_valid               = valid_r;
  assign out_true_positive_rate  = tpr_r;
  assign out_false_positive_rate = fpr_r;
  assign out_tp_count            = otp_r;
  assign out_fp_count            = ofp_r;
  assign out_tn_count            = otn_r;
  assign out_fn_count            = ofn_r;
  assign out_tpr_undefined       = tpu_r;
  assign out_fpr_undefined       = fpu_r;

  always_comb begin
    state_nxt = state_r;
    tp_nxt = tp_r;
    fp_nxt = fp_r;
    tn_nxt = tn_r;
    fn_nxt = fn_r;
    otp_nxt = otp_r;
    ofp_nxt = ofp_r;
    otn_nxt = otn_r;
    ofn_nxt = ofn_r;
    tpr_nxt = tpr_r;
    fpr_nxt = fpr_r;
    tpu_nxt = tpu_r;
    fpu_nxt = fpu_r;
    valid_nxt = valid_r && out_stall;
    sel_nxt  = sel_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    pop      = 1'b0;

    num = sel_r ? ofp_r : otp_r;
    oth = sel_r ? otn_r : ofn_r;
    den_sum  = DEN_W'(num) + DEN_W'(oth);
    // num * 2^16 plus half the denominator, for round half up
    dividend = {1'b0, num, FRAC_W'(0)} + DIVD_W'(den_r[DEN_W-1:1]);
    trial    = {rem_r, quo_r[RATE_W-1]};
    ge       = trial >= {1'b0, den_r};

    tp_inc = (head.cls == CLS_TP) ? sat_inc(tp_r) : tp_r;
    fp_inc = (head.cls == CLS_FP) ? sat_inc(fp_r) : fp_r;
    tn_inc = (head.cls == CLS_TN) ? sat_inc(tn_r) : tn_r;
    fn_inc = (head.cls == CLS_FN) ? sat_inc(fn_r) : fn_r;

    unique case (state_r)
      BK_COUNT: begin
        // the closing voxel waits until the previous result is taken
        pop = head_valid && (!head.last || !valid_r);
        if (pop) begin
          if (head.last) begin
            otp_nxt   = tp_inc;
            ofp_nxt   = fp_inc;
            otn_nxt   = tn_inc;
            ofn_nxt   = fn_inc;
            tp_nxt    = '0;
            fp_nxt    = '0;
            tn_nxt    = '0;
            fn_nxt    = '0;
            sel_nxt   = 1'b0;
            state_nxt = BK_LOAD;
          end else begin
            tp_nxt = tp_inc;
            fp_nxt = fp_inc;
            tn_nxt = tn_inc;
            fn_nxt = fn_inc;
          end
        end
      end
      BK_LOAD: begin
        den_nxt = den_sum;
        if (den_sum == '0) begin
          if (sel_r) begin
            fpu_nxt   = 1'b1;
            fpr_nxt   = '0;
            valid_nxt = 1'b1;
            state_nxt = BK_COUNT;
          end else begin
            tpu_nxt = 1'b1;
            tpr_nxt = '0;
            sel_nxt = 1'b1;
          end
        end else begin
          if (sel_r) begin
            fpu_nxt = 1'b0;
          end else begin
            tpu_nxt = 1'b0;
          end
          state_nxt = BK_PREP;
        end
      end
      BK_PREP: begin
        rem_nxt   = DEN_W'(dividend[DIVD_W-1:RATE_W]);
        quo_nxt   = dividend[RATE_W-1:0];
        step_nxt  = '0;
        state_nxt = BK_STEP;
      end
      BK_STEP: begin
        // restoring division, one quotient bit per cycle shifted into quo
        rem_nxt  = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        quo_nxt  = {quo_r[RATE_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(RATE_W - 1)) begin
          if (sel_r) begin
            fpr_nxt   = quo_nxt;
            valid_nxt = 1'b1;
            state_nxt = BK_COUNT;
          end else begin
            tpr_nxt   = quo_nxt;
            sel_nxt   = 1'b1;
            state_nxt = BK_LOAD;
          end
        end
      end
      default: state_nxt = BK_COUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_COUNT;
      tp_r    <= '0;
      fp_r    <= '0;
      tn_r    <= '0;
      fn_r    <= '0;
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tp_r    <= tp_nxt;
      fp_r    <= fp_nxt;
      tn_r    <= tn_nxt;
      fn_r    <= fn_nxt;
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    otp_r  <= otp_nxt;
    ofp_r  <= ofp_nxt;
    otn_r  <= otn_nxt;
    ofn_r  <= ofn_nxt;
    tpr_r  <= tpr_nxt;
    fpr_r  <= fpr_nxt;
    tpu_r  <= tpu_nxt;
    fpu_r  <= fpu_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

endmodule

/* sv/voxel_confusion_counter.sv */
// top level of the voxel confusion counter: configuration registers and wiring
//
// Voxels of one volume arrive on the in_ channel in raster order, x fastest,
// each a Q8.8 score and a truth label; a transaction completes when in_valid
// is high and in_stall is low. The block keeps the coordinates itself.
// Only the final voxel of a volume produces a transaction on the out_ channel:
// the four counts, both Q1.16 rates and their undefined flags.
// Voxels are taken one per cycle unless the queue is full (in_stall high); a
// four-entry queue sits between intake and the counters. After the final
// voxel the rate divider runs twice, once per rate (load, prepare and 17
// quotient steps), or only its load step when that rate's denominator is
// zero; meanwhile the next volume keeps entering until the queue is full.
// If out_stall holds the result, counting of the next volume goes on and only
// its final voxel waits. The cfg_ port writes registers; the user must use it
// only while the block is idle, which the block itself does not enforce.
// Reset (rst_n low, synchronous) clears coordinates, counters and the queue
// and restores the register defaults.
`timescale 1ns / 1ps

module voxel_confusion_counter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vcc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [vcc_pkg::SCORE_W-1:0] in_score,
  input  logic [vcc_pkg::LABEL_W-1:0]        in_truth_label,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [vcc_pkg::RATE_W-1:0]         out_true_positive_rate,
  output logic [vcc_pkg::RATE_W-1:0]         out_false_positive_rate,
  output logic [vcc_pkg::CNT_W-1:0]          out_tp_count,
  output logic [vcc_pkg::CNT_W-1:0]          out_fp_count,
  output logic [vcc_pkg::CNT_W-1:0]          out_tn_count,
  output logic [vcc_pkg::CNT_W-1:0]          out_fn_count,
  output logic                               out_tpr_undefined,
  output logic                               out_fpr_undefined
);
  import vcc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  q_entry_t push_entry, head;
  logic     push, pop, head_valid, q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg_nxt.threshold = cfg_wdata;
        REG_WIDTH:     cfg_nxt.width     = cfg_wdata[DIM_W-1:0];
        REG_HEIGHT:    cfg_nxt.height    = cfg_wdata[DIM_W-1:0];
        REG_DEPTH:     cfg_nxt.depth     = cfg_wdata[DIM_W-1:0];
        REG_MARGIN:    cfg_nxt.margin    = cfg_wdata[MARGIN_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= '0;
      cfg_r.width     <= DIM_W'(RST_DIM);
      cfg_r.height    <= DIM_W'(RST_DIM);
      cfg_r.depth     <= DIM_W'(RST_DIM);
      cfg_r.margin    <= MARGIN_W'(RST_MARGIN);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vcc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_score       (in_score),
    .in_truth_label (in_truth_label),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  vcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  vcc_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .head                    (head),
    .head_valid              (head_valid),
    .pop                     (pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_true_positive_rate  (out_true_positive_rate),
    .out_false_positive_rate (out_false_positive_rate),
    .out_tp_count            (out_tp_count),
    .out_fp_count            (out_fp_count),
    .out_tn_count            (out_tn_count),
    .out_fn_count            (out_fn_count),
    .out_tpr_undefined       (out_tpr_undefined),
    .out_fpr_undefined       (out_fpr_undefined)
  );

endmodule

/* sv/vcc_checker.sv */
// port-level checks for the voxel confusion counter, bound to the top level
`timescale 1ns / 1ps
`include "voxel_confusion_counter_macros.svh"

module vcc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [vcc_pkg::RATE_W-1:0]    out_true_positive_rate,
  input logic [vcc_pkg::RATE_W-1:0]    out_false_positive_rate,
  input logic [vcc_pkg::CNT_W-1:0]     out_tp_count,
  input logic [vcc_pkg::CNT_W-1:0]     out_fp_count,
  input logic [vcc_pkg::CNT_W-1:0]     out_tn_count,
  input logic [vcc_pkg::CNT_W-1:0]     out_fn_count,
  input logic                          out_tpr_undefined,
  input logic                          out_fpr_undefined
);
  import vcc_pkg::*;

  // a held result stays offered
  `VCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // undefined flag matches an empty denominator
  `VCC_ASSERT_IMP(a_tpr_flag, out_valid, out_tpr_undefined == ((out_tp_count == '0) && (out_fn_count == '0)))
  `VCC_ASSERT_IMP(a_fpr_flag, out_valid, out_fpr_undefined == ((out_fp_count == '0) && (out_tn_count == '0)))

  // rates never pass one, and the true positive rate reads zero when flagged
  `VCC_ASSERT_IMP(a_rate_range, out_valid, (out_true_positive_rate <= RATE_W'(1 << FRAC_W)) && (out_false_positive_rate <= RATE_W'(1 << FRAC_W)))
  `VCC_ASSERT_IMP(a_undef_zero, out_valid && out_tpr_undefined, out_true_positive_rate == '0)

endmodule

bind voxel_confusion_counter vcc_checker u_vcc_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_true_positive_rate  (out_true_positive_rate),
  .out_false_positive_rate (out_false_positive_rate),
  .out_tp_count            (out_tp_count),
  .out_fp_count            (out_fp_count),
  .out_tn_count            (out_tn_count),
  .out_fn_count            (out_fn_count),
  .out_tpr_undefined       (out_tpr_undefined),
  .out_fpr_undefined       (out_fpr_undefined)
);

/* bench/voxel_confusion_counter_tb.sv */
// self-checking testbench for the voxel confusion counter
`timescale 1ns / 1ps

module voxel_confusion_counter_tb;
  import vcc_pkg::*;

  localparam int ITEMS_TOTAL  = 1850;
  localparam int DRAIN_CYCLES = 64;   // covers both divider runs, plus the queue
  localparam int QUIET_LIMIT  = 3000;
  localparam int PRINT_CAP    = 200;

  typedef struct {
    logic [RATE_W-1:0] tpr;
    logic [RATE_W-1:0] fpr;
    logic [CNT_W-1:0]  tp;
    logic [CNT_W-1:0]  fp;
    logic [CNT_W-1:0]  tn;
    logic [CNT_W-1:0]  fn;
    logic              tpr_undef;
    logic              fpr_undef;
  } volume_summary_t;

  // mirrors the block: raster position, four counters and the summary per volume
  class volume_tally;
    logic signed [SCORE_W-1:0] threshold;
    logic [DIM_W-1:0]          width;
    logic [DIM_W-1:0]          height;
    logic [DIM_W-1:0]          depth;
    logic [MARGIN_W-1:0]       margin;
    int unsigned               x_pos, y_pos, z_pos;
    logic [CNT_W-1:0]          tp, fp, tn, fn;
    volume_summary_t           pending_summaries[$];
    int                        mismatches;

    function new();
      threshold  = '0;
      width      = DIM_W'(RST_DIM);
      height     = DIM_W'(RST_DIM);
      depth      = DIM_W'(RST_DIM);
      margin     = MARGIN_W'(RST_MARGIN);
      mismatches = 0;
      clear_volume();
    endfunction

    function void clear_volume();
      x_pos = 0;
      y_pos = 0;
      z_pos = 0;
      tp = '0;
      fp = '0;
      tn = '0;
      fn = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD: threshold = $signed(data[SCORE_W-1:0]);
        REG_WIDTH:     width     = data[DIM_W-1:0];
        REG_HEIGHT:    height    = data[DIM_W-1:0];
        REG_DEPTH:     depth     = data[DIM_W-1:0];
        REG_MARGIN:    margin    = data[MARGIN_W-1:0];
        default: ;
      endcase
    endfunction

    // zero behaves as one, oversize is clamped to the largest volume
    function int unsigned clamp_dim(logic [DIM_W-1:0] d);
      if (d == '0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return d;
    endfunction

    function bit clear_of_border(int unsigned p, int unsigned dim);
      return (p >= margin) && (p + margin < dim);
    endfunction

    function logic [CNT_W-1:0] plus_one(logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // q1.16 ratio, half rounds up, zero denominator flagged
    function void ratio(input logic [CNT_W-1:0] num, input logic [CNT_W-1:0] other,
                        output logic [RATE_W-1:0] r, output logic undef);
      logic [63:0] den;
      logic [63:0] q;
      den   = 64'(num) + 64'(other);
      undef = (den == 0);
      q     = undef ? 64'd0 : ((64'(num) << FRAC_W) + den / 2) / den;
      r     = q[RATE_W-1:0];
    endfunction

    function void note_voxel(logic signed [SCORE_W-1:0] score, logic [LABEL_W-1:0] label);
      int unsigned     w, h, d;
      bit              x_end, y_end, z_end, positive, detected;
      volume_summary_t s;
      w = clamp_dim(width);
      h = clamp_dim(height);
      d = clamp_dim(depth);
      positive = (label == '0);
      detected = (score >= threshold);
      x_end = (x_pos + 1 >= w);
      y_end = (y_pos + 1 >= h);
      z_end = (z_pos + 1 >= d);
      if (clear_of_border(x_pos, w) && clear_of_border(y_pos, h) &&
          clear_of_border(z_pos, d)) begin
        if (detected) begin
          if (positive) tp = plus_one(tp);
          else fp = plus_one(fp);
        end else begin
          if (positive) fn = plus_one(fn);
          else tn = plus_one(tn);
        end
      end
      if (x_end && y_end && z_end) begin
        ratio(tp, fn, s.tpr, s.tpr_undef);
        ratio(fp, tn, s.fpr, s.fpr_undef);
        s.tp = tp;
        s.fp = fp;
        s.tn = tn;
        s.fn = fn;
        pending_summaries = {pending_summaries, s};
        clear_volume();
        return;
      end
      // a shrunken axis makes any position at or past its end wrap
      if (!x_end) begin
        x_pos++;
      end else begin
        x_pos = 0;
        if (!y_end) begin
          y_pos++;
        end else begin
          y_pos = 0;
          z_pos++;
        end
      end
    endfunction

    function int pending();
      return pending_summaries.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t ns: %s", $time, what);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task check_summary(volume_summary_t got);
      volume_summary_t want;
      if (pending_summaries.size() == 0) begin
        report_mismatch("volume summary arrived with none outstanding");
        return;
      end
      want = pending_summaries.pop_front();
      compare_field("true_positive_rate", got.tpr, want.tpr);
      compare_field("false_positive_rate", got.fpr, want.fpr);
      compare_field("tp_count", got.tp, want.tp);
      compare_field("fp_count", got.fp, want.fp);
      compare_field("tn_count", got.tn, want.tn);
      compare_field("fn_count", got.fn, want.fn);
      compare_field("tpr_undefined", got.tpr_undef, want.tpr_undef);
      compare_field("fpr_undefined", got.fpr_undef, want.fpr_undef);
    endtask
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SCORE_W-1:0]  in_score;
  logic [LABEL_W-1:0]         in_truth_label;
  logic                       out_valid;
  logic                       out_stall;
  logic [RATE_W-1:0]          out_true_positive_rate;
  logic [RATE_W-1:0]          out_false_positive_rate;
  logic [CNT_W-1:0]           out_tp_count;
  logic [CNT_W-1:0]           out_fp_count;
  logic [CNT_W-1:0]           out_tn_count;
  logic [CNT_W-1:0]           out_fn_count;
  logic                       out_tpr_undefined;
  logic                       out_fpr_undefined;

  volume_tally     tally;
  volume_summary_t got_summary;
  int              voxels_sent;
  int              summaries_seen;
  int              burst_left;
  int              stall_run;
  bit              stall_mode;
  int              quiet_cycles;

  voxel_confusion_counter u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_score                (in_score),
    .in_truth_label          (in_truth_label),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_true_positive_rate  (out_true_positive_rate),
    .out_false_positive_rate (out_false_positive_rate),
    .out_tp_count            (out_tp_count),
    .out_fp_count            (out_fp_count),
    .out_tn_count            (out_tn_count),
    .out_fn_count            (out_fn_count),
    .out_tpr_undefined       (out_tpr_undefined),
    .out_fpr_undefined       (out_fpr_undefined)
  );

  always #6 clk = ~clk;

  // sender works in bursts; a gap of zero keeps valid high across transactions
  task automatic send_voxel(input logic signed [SCORE_W-1:0] score,
                            input logic [LABEL_W-1:0] label);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_score       <= score;
    in_truth_label <= label;
    do @(posedge clk); while (in_stall);
    tally.note_voxel(score, label);
    voxels_sent++;
  endtask

  task automatic send_random_voxel();
    logic signed [SCORE_W-1:0] s;
    logic [LABEL_W-1:0]        l;
    int                        pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: s = tally.threshold + SCORE_W'($urandom_range(0, 2)) - 1'b1;
      3, 4, 5: s = SCORE_W'($urandom);
      6:       s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: s = SCORE_W'($urandom_range(0, 2048)) - 16'sd1024;
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 9) l = '0;
    else if (pick < 11) l = '1;
    else l = LABEL_W'($urandom_range(1, 255));
    send_voxel(s, l);
  endtask

  // wait until the block has drained every transaction in flight
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (tally.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tally.set_reg(idx, data);
  endtask

  task automatic set_volume(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] w,
                            input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] d,
                            input logic [CFG_DATA_W-1:0] m);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_DEPTH, d);
    write_reg(REG_MARGIN, m);
    // unmapped indexes must leave every register alone
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_MARGIN + 1, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int used);
    if ($urandom_range(0, 3) != 0) return v;
    return v | (CFG_DATA_W'($urandom) << used);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0, 1:    return CFG_DATA_W'($urandom);
      2:       return 16'h8000;
      3:       return 16'h7fff;
      default: return CFG_DATA_W'($urandom_range(0, 1024)) - 16'd512;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 19))
      0:       v = '0;
      1:       v = CFG_DATA_W'(MAX_DIM);
      2:       v = CFG_DATA_W'($urandom_range(MAX_DIM + 1, 2047));
      3, 4:    v = CFG_DATA_W'($urandom_range(5, 9));
      default: v = CFG_DATA_W'($urandom_range(1, 4));
    endcase
    return with_junk(v, DIM_W);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_margin();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'd15;
      1:       v = CFG_DATA_W'($urandom_range(2, 14));
      2, 3, 4: v = 16'd1;
      default: v = '0;
    endcase
    return with_junk(v, MARGIN_W);
  endfunction

  // result side: check each transaction, stall on a pattern of its own
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_summary.tpr       = out_true_positive_rate;
      got_summary.fpr       = out_false_positive_rate;
      got_summary.tp        = out_tp_count;
      got_summary.fp        = out_fp_count;
      got_summary.tn        = out_tn_count;
      got_summary.fn        = out_fn_count;
      got_summary.tpr_undef = out_tpr_undefined;
      got_summary.fpr_undef = out_fpr_undefined;
      tally.check_summary(got_summary);
      summaries_seen++;
    end
    if (stall_run == 0) begin
      stall_mode = !stall_mode;
      if (stall_mode) stall_run = $urandom_range(1, 10);
      else stall_run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                   : $urandom_range(1, 20);
    end
    stall_run--;
    out_stall <= stall_mode && ($urandom_range(0, 3) != 0);
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_THRESHOLD;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_score       = '0;
    in_truth_label = '0;
    out_stall      = 1'b0;
    voxels_sent    = 0;
    summaries_seen = 0;
    burst_left     = 0;
    stall_run      = 0;
    stall_mode     = 1'b1;
    quiet_cycles   = 0;
    tally          = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait_quiet();

    // single-voxel volumes: each class and the score extremes
    set_volume(16'h0000, 16'd1, 16'd1, 16'd1, 16'd0);
    send_voxel(16'sh8000, 8'h00);
    send_voxel(16'sh7fff, 8'h00);
    send_voxel(16'sh0000, 8'h00);
    send_voxel(-16'sd1, 8'hff);
    send_voxel(16'sh0000, 8'h01);
    send_voxel(16'sh7fff, 8'h80);
    wait_quiet();
    // zero dimensions behave as one, threshold at its top
    set_volume(16'h7fff, 16'd0, 16'd0, 16'd0, 16'd0);
    send_voxel(16'sh7fff, 8'h00);
    send_voxel(16'sh7ffe, 8'h00);
    wait_quiet();
    set_volume(16'h8000, 16'd1, 16'd1, 16'd1, 16'd0);
    send_voxel(16'sh8000, 8'h55);
    send_voxel(16'sh8000, 8'h00);
    wait_quiet();
    // margin wider than the volume: nothing counted, both rates undefined
    set_volume(16'h0000, 16'd3, 16'd1, 16'd1, 16'd15);
    repeat (3) send_voxel(16'sh0100, 8'h00);
    wait_quiet();
    // rounding of a third and of a half
    set_volume(16'h0100, 16'd5, 16'd1, 16'd1, 16'd0);
    send_voxel(16'sh0100, 8'h00);
    send_voxel(16'sh00ff, 8'h00);
    send_voxel(16'sh0000, 8'h00);
    send_voxel(16'sh7000, 8'h03);
    send_voxel(-16'sd5, 8'hc8);
    wait_quiet();
    // volume shrunk under a half-done scan ends it at once
    set_volume(16'h0000, 16'd4, 16'd4, 16'd1, 16'd1);
    send_voxel(16'sh0040, 8'h00);
    send_voxel(-16'sd64, 8'h02);
    wait_quiet();
    set_volume(16'h0000, 16'd2, 16'd1, 16'd1, 16'd0);
    send_voxel(16'sh0001, 8'h00);
    wait_quiet();

    // one long line along an oversized axis
    set_volume(pick_threshold(), 16'd1, with_junk(16'd2047, DIM_W), 16'd0,
               16'($urandom_range(0, 3)));
    repeat (MAX_DIM) send_random_voxel();
    wait_quiet();

    while (voxels_sent < ITEMS_TOTAL) begin
      set_volume(pick_threshold(), pick_dim(), pick_dim(), pick_dim(), pick_margin());
      repeat ($urandom_range(8, 80)) send_random_voxel();
      wait_quiet();
    end

    if (tally.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/vcc_pkg.sv
sv/vcc_front.sv
sv/vcc_queue.sv
sv/vcc_back.sv
sv/voxel_confusion_counter.sv
sv/vcc_checker.sv
bench/voxel_confusion_counter_tb.sv
